// ===== src/tsa_pkg.sv =====
// Shared types and constants of the tile slot allocator.
package tsa_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int SLOT_W = 9;
    localparam int STATUS_W = 3;
    localparam int OP_W = 2;
    localparam int IN_ID_W = 32;
    localparam int CFG_W = 10;
    localparam logic [CFG_W-1:0] MAX_SLOTS_RST = 10'd448;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RESIDENT   = 3'd0,
        ST_LOADED_OFF = 3'd1,
        ST_LOADED_ON  = 3'd2,
        ST_ABSENT     = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_BEGIN,
        SW_END,
        SW_SCAN
    } sweep_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BEGIN,
        S_END,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic   capture;
        logic   run;
        sweep_t mode;
        logic   commit;
        logic   push;
    } cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic out_free;
    } stat_t;

endpackage

// ===== src/tsa_ctrl.sv =====
// Sequencing state machine of the tile slot allocator.
module tsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tsa_pkg::op_t   op,
    input  tsa_pkg::stat_t stat,
    output tsa_pkg::cmd_t  cmd
);

    tsa_pkg::fsm_t state_reg;
    tsa_pkg::fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.run     = 1'b0;
        cmd.mode    = tsa_pkg::SW_SCAN;
        cmd.commit  = 1'b0;
        cmd.push    = 1'b0;
        case (state_reg)
            tsa_pkg::S_CLEAR: begin
                cmd.run  = 1'b1;
                cmd.mode = tsa_pkg::SW_CLEAR;
                if (stat.sweep_done) begin
                    state_next = tsa_pkg::S_IDLE;
                end
            end
            tsa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (op)
                        tsa_pkg::OP_BEGIN: state_next = tsa_pkg::S_BEGIN;
                        tsa_pkg::OP_END:   state_next = tsa_pkg::S_END;
                        default:           state_next = tsa_pkg::S_SCAN;
                    endcase
                end
            end
            tsa_pkg::S_BEGIN: begin
                cmd.run  = 1'b1;
                cmd.mode = tsa_pkg::SW_BEGIN;
                if (stat.sweep_done) begin
                    state_next = tsa_pkg::S_COMMIT;
                end
            end
            tsa_pkg::S_END: begin
                cmd.run  = 1'b1;
                cmd.mode = tsa_pkg::SW_END;
                if (stat.sweep_done) begin
                    state_next = tsa_pkg::S_COMMIT;
                end
            end
            tsa_pkg::S_SCAN: begin
                cmd.run  = 1'b1;
                cmd.mode = tsa_pkg::SW_SCAN;
                if (stat.sweep_done) begin
                    state_next = tsa_pkg::S_COMMIT;
                end
            end
            tsa_pkg::S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = tsa_pkg::S_DONE;
            end
            tsa_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = tsa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tsa_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/tsa_datapath.sv =====
// Slot memories, scan counter, candidate tracking and result register.
module tsa_datapath #(
    parameter int SLOTS   = 512,
    parameter int ID_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tsa_pkg::CFG_W-1:0]          cfg_wr_data,
    input  tsa_pkg::op_t                       in_op,
    input  logic [tsa_pkg::IN_ID_W-1:0]        in_id,
    input  tsa_pkg::cmd_t                      cmd,
    output tsa_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tsa_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > tsa_pkg::CFG_W) ? CNT_W : tsa_pkg::CFG_W;
    localparam logic [ID_BITS-1:0] ID_ONES = {ID_BITS{1'b1}};
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    logic [ID_BITS-1:0] tile_mem [SLOTS];
    logic               use_mem  [SLOTS];
    logic               scr_mem  [SLOTS];

    logic [tsa_pkg::CFG_W-1:0] max_slots_reg;
    tsa_pkg::op_t              op_reg;
    logic [ID_BITS-1:0]        id_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]          addr_d_reg;
    logic [ID_BITS-1:0]        tile_rd_reg;
    logic                      use_rd_reg;
    logic                      scr_rd_reg;
    logic [IDX_W-1:0]          last_reg;

    logic                      hit_f_reg, off_up_f_reg, off_lo_f_reg, any_up_f_reg, any_lo_f_reg;
    logic [IDX_W-1:0]          hit_s_reg, off_up_s_reg, off_lo_s_reg, any_up_s_reg, any_lo_s_reg;

    logic [IDX_W-1:0]          res_slot_reg, res_slot_next;
    tsa_pkg::status_t          res_status_reg, res_status_next;
    logic                      m_tvalid_reg;
    logic [tsa_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [CMP_W-1:0]          max_ext, slots_ext;
    logic [CNT_W-1:0]          n_eff, limit;
    logic                      issue;
    logic [IDX_W-1:0]          rd_addr;

    logic                      tile_we, use_we, scr_we;
    logic [IDX_W-1:0]          tile_wa, use_wa, scr_wa;
    logic [ID_BITS-1:0]        tile_wd;
    logic                      use_wd, scr_wd;

    logic                      id_empty, match, free, off, upper, lower;
    logic                      pick_f, pick_on;
    logic [IDX_W-1:0]          pick_s;
    logic [IDX_W+tsa_pkg::SLOT_W-1:0] slot_ext;

    always_comb begin
        max_ext   = CMP_W'(max_slots_reg);
        slots_ext = CMP_W'(SLOTS);
        n_eff     = (max_ext > slots_ext) ? SLOTS_CNT : CNT_W'(max_ext);
        limit     = (cmd.mode == tsa_pkg::SW_SCAN) ? n_eff : SLOTS_CNT;
        issue     = cmd.run && (cnt_reg < limit);
        rd_addr   = cnt_reg[IDX_W-1:0];
        cnt_next  = cmd.capture ? '0 : (issue ? cnt_reg + 1'b1 : cnt_reg);
        rd_vld_next = issue;
        stat.sweep_done = cmd.run && !issue && !rd_vld_reg;
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        id_empty = (id_reg == ID_ONES);
        match    = !id_empty && (tile_rd_reg == id_reg);
        free     = !use_rd_reg;
        off      = free && !scr_rd_reg;
        upper    = addr_d_reg > last_reg;
        lower    = addr_d_reg < last_reg;
    end

    always_comb begin
        pick_f  = 1'b1;
        pick_on = 1'b0;
        pick_s  = off_up_s_reg;
        if (off_up_f_reg) begin
            pick_s = off_up_s_reg;
        end else if (off_lo_f_reg) begin
            pick_s = off_lo_s_reg;
        end else if (any_up_f_reg) begin
            pick_s  = any_up_s_reg;
            pick_on = 1'b1;
        end else if (any_lo_f_reg) begin
            pick_s  = any_lo_s_reg;
            pick_on = 1'b1;
        end else begin
            pick_f = 1'b0;
        end
    end

    always_comb begin
        res_slot_next   = '0;
        res_status_next = tsa_pkg::ST_RESIDENT;
        tile_we = 1'b0;
        tile_wa = rd_addr;
        tile_wd = ID_ONES;
        use_we  = 1'b0;
        use_wa  = rd_addr;
        use_wd  = 1'b0;
        scr_we  = 1'b0;
        scr_wa  = rd_addr;
        scr_wd  = 1'b0;
        if (issue && cmd.mode == tsa_pkg::SW_CLEAR) begin
            tile_we = 1'b1;
            use_we  = 1'b1;
            scr_we  = 1'b1;
        end else if (issue && cmd.mode == tsa_pkg::SW_BEGIN) begin
            use_we = 1'b1;
        end else if (rd_vld_reg && cmd.run && cmd.mode == tsa_pkg::SW_END) begin
            scr_we = 1'b1;
            scr_wa = addr_d_reg;
            scr_wd = use_rd_reg;
        end
        if (cmd.commit) begin
            case (op_reg)
                tsa_pkg::OP_RESERVE: begin
                    if (hit_f_reg) begin
                        res_slot_next = hit_s_reg;
                        use_we = 1'b1;
                        use_wa = hit_s_reg;
                        use_wd = 1'b1;
                    end else begin
                        res_status_next = tsa_pkg::ST_ABSENT;
                    end
                end
                tsa_pkg::OP_LOAD: begin
                    if (hit_f_reg) begin
                        res_slot_next = hit_s_reg;
                    end else if (id_empty || !pick_f) begin
                        res_status_next = tsa_pkg::ST_FULL;
                    end else begin
                        res_slot_next   = pick_s;
                        res_status_next = pick_on ? tsa_pkg::ST_LOADED_ON
                                                  : tsa_pkg::ST_LOADED_OFF;
                        tile_we = 1'b1;
                        tile_wa = pick_s;
                        tile_wd = id_reg;
                        use_we  = 1'b1;
                        use_wa  = pick_s;
                        use_wd  = 1'b1;
                    end
                end
                default: begin
                    res_slot_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[tile_wa] <= tile_wd;
        end
        tile_rd_reg <= tile_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (use_we) begin
            use_mem[use_wa] <= use_wd;
        end
        use_rd_reg <= use_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_wa] <= scr_wd;
        end
        scr_rd_reg <= scr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_slots_reg <= tsa_pkg::MAX_SLOTS_RST;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            last_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            hit_f_reg     <= 1'b0;
            off_up_f_reg  <= 1'b0;
            off_lo_f_reg  <= 1'b0;
            any_up_f_reg  <= 1'b0;
            any_lo_f_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_slots_reg <= cfg_wr_data;
            end
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            if (cmd.push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.commit && op_reg == tsa_pkg::OP_LOAD && !hit_f_reg && !id_empty
                && pick_f) begin
                last_reg <= pick_s;
            end
            if (cmd.capture) begin
                hit_f_reg    <= 1'b0;
                off_up_f_reg <= 1'b0;
                off_lo_f_reg <= 1'b0;
                any_up_f_reg <= 1'b0;
                any_lo_f_reg <= 1'b0;
            end else if (rd_vld_reg && cmd.run && cmd.mode == tsa_pkg::SW_SCAN) begin
                if (match && !hit_f_reg) begin
                    hit_f_reg <= 1'b1;
                end
                if (off && upper && !off_up_f_reg) begin
                    off_up_f_reg <= 1'b1;
                end
                if (off && lower && !off_lo_f_reg) begin
                    off_lo_f_reg <= 1'b1;
                end
                if (free && upper && !any_up_f_reg) begin
                    any_up_f_reg <= 1'b1;
                end
                if (free && lower && !any_lo_f_reg) begin
                    any_lo_f_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_d_reg <= rd_addr;
        if (cmd.capture) begin
            op_reg <= in_op;
            id_reg <= in_id[ID_BITS-1:0];
        end
        if (rd_vld_reg && cmd.run && cmd.mode == tsa_pkg::SW_SCAN) begin
            if (match && !hit_f_reg) begin
                hit_s_reg <= addr_d_reg;
            end
            if (off && upper && !off_up_f_reg) begin
                off_up_s_reg <= addr_d_reg;
            end
            if (off && lower && !off_lo_f_reg) begin
                off_lo_s_reg <= addr_d_reg;
            end
            if (free && upper && !any_up_f_reg) begin
                any_up_s_reg <= addr_d_reg;
            end
            if (free && lower && !any_lo_f_reg) begin
                any_lo_s_reg <= addr_d_reg;
            end
        end
        if (cmd.commit) begin
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.push) begin
            m_tdata_reg <= {4'b0, res_status_reg, slot_ext[tsa_pkg::SLOT_W-1:0]};
        end
    end

    assign slot_ext = {{tsa_pkg::SLOT_W{1'b0}}, res_slot_reg};
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/tile_slot_allocator.sv =====
// Top level of the tile slot allocator: controller, datapath and checks.
//
// Usage: each input transfer carries an opcode and a catalog tile id; each
// yields exactly one result transfer with a slot number and a status.
//   begin frame - clear every in-use mark
//   reserve     - mark the slot holding the id in use
//   load        - return the resident slot, or claim a free one
//   end frame   - copy the in-use marks to the on-screen marks
// Sweeps: reserve and load sweep the n usable slots one per cycle, where n
// is max_slots clamped to SLOTS. Begin and end frame sweep all SLOTS
// entries. The next input can be taken in the cycle after the result is
// stored. One item is in work at a time.
// After reset a clearing pass over all SLOTS entries empties every slot;
// s_tready stays low until it ends. cfg_wr_en writes max_slots (reset 448).
// The result sits in an output register: a stalled receiver does not block
// the next input transfer, but that item's result waits until the held one
// is taken, and no further input is taken meanwhile.
module tile_slot_allocator #(
    parameter int SLOTS   = 512,
    parameter int ID_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tsa_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] opcode, [33:2] tile_id, [39:34] zero
    input  logic [tsa_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [8:0] slot, [11:9] status, [15:12] zero
    output logic [tsa_pkg::M_TDATA_W-1:0]     m_tdata
);

    tsa_pkg::cmd_t  cmd;
    tsa_pkg::stat_t stat;
    tsa_pkg::op_t   in_op;
    logic [tsa_pkg::IN_ID_W-1:0] in_id;

    assign in_op = tsa_pkg::op_t'(s_tdata[tsa_pkg::OP_W-1:0]);
    assign in_id = s_tdata[tsa_pkg::OP_W+tsa_pkg::IN_ID_W-1:tsa_pkg::OP_W];

    tsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (in_op),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsa_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_op       (in_op),
        .in_id       (in_id),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTH
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:9] <= tsa_pkg::ST_FULL))
        else $error("undefined status code");

    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[11:9] == tsa_pkg::ST_ABSENT
            || m_tdata[11:9] == tsa_pkg::ST_FULL)) |-> (m_tdata[8:0] == 9'd0))
        else $error("failed request reports a nonzero slot");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_tvalid || m_tready))
        else $error("result overwrites an untaken transfer");
`endif

endmodule
